/* sv/tclw_pkg.sv */
// Text console line writer: shared package.
// Holds the result kind codes, register indexes, command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package tclw_pkg;

  // Result kinds on the output channel
  localparam logic [1:0] KIND_VIDEO  = 2'd0;
  localparam logic [1:0] KIND_ORIGIN = 2'd1;
  localparam logic [1:0] KIND_CURSOR = 2'd2;

  // Which result the datapath builds on an emit command
  localparam logic [1:0] EMIT_FLUSH  = 2'd0;
  localparam logic [1:0] EMIT_BLANK  = 2'd1;
  localparam logic [1:0] EMIT_ORIGIN = 2'd2;
  localparam logic [1:0] EMIT_CURSOR = 2'd3;

  // Register map (index taken from paddr[2])
  localparam int         PADDR_W       = 3;
  localparam logic       REG_ATTRIBUTE = 1'b0;
  localparam logic       REG_BLANK     = 1'b1;
  localparam logic [7:0]  ATTR_RESET   = 8'd31;
  localparam logic [15:0] BLANK_RESET  = 16'd7936;

  // Input decode
  localparam logic       OP_PUT       = 1'b0;
  localparam logic       OP_FLUSH     = 1'b1;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // Number of cell word ports on a result beat
  localparam int OUT_CELLS = 4;

  // Controller to datapath
  typedef struct packed {
    logic       take;           // capture the input beat
    logic       buf_write;      // store the cell, advance the column
    logic       flush_start;    // begin a flush walk over the line buffer
    logic       blank_start;    // begin a blank walk over the bottom line
    logic       chunk_advance;  // step to the next group of cells
    logic       line_advance;   // next row, scroll when on the bottom row
    logic       emit;           // load the result register
    logic [1:0] emit_sel;
    logic       emit_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_flush;
    logic newline;
    logic column_zero;
    logic line_full;
    logic last_row;
    logic chunk_final;
    logic out_free;
  } stat_t;

endpackage

/* sv/text_console_line_writer_core.sv */
// Text console line writer: top level.
// Joins tclw_ctrl and tclw_dpath; uses tclw_pkg.
`timescale 1ns / 1ps

// Takes one beat per character or flush command and produces the video memory,
// origin register and cursor register writes for a text console; addresses are
// cell offsets from the start of video memory. A printable character is stored
// in the line buffer and then presents its cursor beat. Each group of
// CELLS_PER_RESULT cells written back from the line buffer passes through a line
// buffer read state and then a result beat state. A scroll adds one origin beat
// and (LINE_WIDTH + CELLS_PER_RESULT - 1) / CELLS_PER_RESULT blank beats, one a
// cycle while the result side does not stall. The next item is taken once the
// previous one has issued its last beat; stalls on the result side hold it back.
// No clearing pass is needed after reset.
module text_console_line_writer_core #(
  parameter int LINE_WIDTH       = 80,
  parameter int SCREEN_LINES     = 25,
  parameter int VIDEO_CELLS      = 16384,
  parameter int CELLS_PER_RESULT = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tclw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input channel
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         op,
  input  logic [7:0]                   char_code,
  // result channel
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [1:0]                   kind,
  output logic [13:0]                  cell_address,
  output logic [15:0]                  cell_zero,
  output logic [15:0]                  cell_one,
  output logic [15:0]                  cell_two,
  output logic [15:0]                  cell_three,
  output logic [2:0]                   cell_count,
  output logic [13:0]                  register_value,
  output logic                         last
);

  tclw_pkg::cmd_t  cmd;
  tclw_pkg::stat_t stat;

  // Sequencer
  tclw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Buffer, counters and result register
  tclw_dpath #(
    .LINE_WIDTH       (LINE_WIDTH),
    .SCREEN_LINES     (SCREEN_LINES),
    .VIDEO_CELLS      (VIDEO_CELLS),
    .CELLS_PER_RESULT (CELLS_PER_RESULT)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .op             (op),
    .char_code      (char_code),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .cell_address   (cell_address),
    .cell_zero      (cell_zero),
    .cell_one       (cell_one),
    .cell_two       (cell_two),
    .cell_three     (cell_three),
    .cell_count     (cell_count),
    .register_value (register_value),
    .last           (last)
  );

endmodule

/* sv/tclw_ctrl.sv */
// Text console line writer: controller state machine.
// Sequences one input beat into its result beats; uses tclw_pkg.
`timescale 1ns / 1ps

module tclw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  tclw_pkg::stat_t stat,
  output tclw_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_POST     = 4'd2;
  localparam logic [3:0] S_FL_READ  = 4'd3;
  localparam logic [3:0] S_FL_EMIT  = 4'd4;
  localparam logic [3:0] S_ADVANCE  = 4'd5;
  localparam logic [3:0] S_ORIGIN   = 4'd6;
  localparam logic [3:0] S_BLANK    = 4'd7;
  localparam logic [3:0] S_CURSOR   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // Take a new beat only when nothing is in progress
  assign item_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.op_flush || stat.newline) begin
          if (stat.column_zero) begin
            state_next = stat.op_flush ? S_IDLE : S_ADVANCE;
          end else begin
            cmd.flush_start = 1'b1;
            state_next      = S_FL_READ;
          end
        end else begin
          cmd.buf_write = 1'b1;
          state_next    = S_POST;
        end
      end
      S_POST: begin
        if (stat.line_full) begin
          cmd.flush_start = 1'b1;
          state_next      = S_FL_READ;
        end else begin
          state_next = S_CURSOR;
        end
      end
      S_FL_READ: begin
        state_next = S_FL_EMIT;
      end
      S_FL_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = tclw_pkg::EMIT_FLUSH;
          cmd.emit_last = stat.chunk_final && stat.op_flush;
          if (stat.chunk_final) begin
            state_next = stat.op_flush ? S_IDLE : S_ADVANCE;
          end else begin
            cmd.chunk_advance = 1'b1;
            state_next        = S_FL_READ;
          end
        end
      end
      S_ADVANCE: begin
        cmd.line_advance = 1'b1;
        if (stat.last_row) begin
          cmd.blank_start = 1'b1;
          state_next      = S_ORIGIN;
        end else begin
          state_next = S_CURSOR;
        end
      end
      S_ORIGIN: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = tclw_pkg::EMIT_ORIGIN;
          state_next   = S_BLANK;
        end
      end
      S_BLANK: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = tclw_pkg::EMIT_BLANK;
          if (stat.chunk_final) begin
            state_next = S_CURSOR;
          end else begin
            cmd.chunk_advance = 1'b1;
          end
        end
      end
      S_CURSOR: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = tclw_pkg::EMIT_CURSOR;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  // A flush beat always follows a buffer read cycle
  a_flush_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_FL_EMIT |-> $past(state) == S_FL_READ || $past(state) == S_FL_EMIT)
    else $error("flush beat without a preceding buffer read");

  // Results come only from the emitting states
  a_emit_states: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> state == S_FL_EMIT || state == S_ORIGIN || state == S_BLANK ||
                 state == S_CURSOR)
    else $error("emit outside an emitting state");

  // A flush walk ends either the item or moves on to the next row
  a_flush_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_FL_EMIT && cmd.emit && stat.chunk_final && !stat.op_flush
      |=> state == S_ADVANCE)
    else $error("line flush not followed by row advance");
`endif

endmodule

/* sv/tclw_dpath.sv */
// Text console line writer: datapath.
// Line buffer banks, position counters, address wrap, registers and result register.
// Uses tclw_pkg; driven by tclw_ctrl.
`timescale 1ns / 1ps

module tclw_dpath #(
  parameter int LINE_WIDTH       = 80,
  parameter int SCREEN_LINES     = 25,
  parameter int VIDEO_CELLS      = 16384,
  parameter int CELLS_PER_RESULT = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tclw_pkg::cmd_t               cmd,
  output tclw_pkg::stat_t              stat,
  // input beat
  input  logic                         op,
  input  logic [7:0]                   char_code,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tclw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // result beat
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [1:0]                   kind,
  output logic [13:0]                  cell_address,
  output logic [15:0]                  cell_zero,
  output logic [15:0]                  cell_one,
  output logic [15:0]                  cell_two,
  output logic [15:0]                  cell_three,
  output logic [2:0]                   cell_count,
  output logic [13:0]                  register_value,
  output logic                         last
);

  localparam int CW    = $clog2(LINE_WIDTH + 1);
  localparam int RW    = $clog2(SCREEN_LINES);
  localparam int AW    = $clog2(VIDEO_CELLS);
  localparam int NROWS = (LINE_WIDTH + CELLS_PER_RESULT - 1) / CELLS_PER_RESULT;
  localparam int BW    = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int LANEW = (CELLS_PER_RESULT > 1) ? $clog2(CELLS_PER_RESULT) : 1;

  // Add two offsets below the video size, wrapping once
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AW+1)'(VIDEO_CELLS)) begin
      sum = sum - (AW+1)'(VIDEO_CELLS);
    end
    return sum[AW-1:0];
  endfunction

  logic           item_op;
  logic [7:0]     item_char;
  logic [7:0]     attribute;
  logic [15:0]    blank;
  logic [CW-1:0]  column;
  logic [LANEW-1:0] wr_lane;
  logic [BW-1:0]  wr_row;
  logic [RW-1:0]  row;
  logic [AW-1:0]  line_base;
  logic [AW-1:0]  origin;
  logic [CW-1:0]  offset;
  logic [BW-1:0]  rd_row;
  logic           limit_blank;
  logic [15:0]    rdata [CELLS_PER_RESULT];
  logic [15:0]    cell_q [tclw_pkg::OUT_CELLS];
  logic [15:0]    cell_src [tclw_pkg::OUT_CELLS];
  logic [CW-1:0]  limit;
  logic [CW-1:0]  remaining;
  logic [CW-1:0]  n_cells;
  logic           chunk_final;
  logic [CW-1:0]  addend;
  logic [AW-1:0]  addr_sum;
  logic           cfg_write;

  // Configuration registers
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= tclw_pkg::ATTR_RESET;
      blank     <= tclw_pkg::BLANK_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        tclw_pkg::REG_ATTRIBUTE: attribute <= pwdata[7:0];
        tclw_pkg::REG_BLANK:     blank     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tclw_pkg::REG_ATTRIBUTE: prdata = {24'd0, attribute};
      tclw_pkg::REG_BLANK:     prdata = {16'd0, blank};
      default:                 prdata = '0;
    endcase
  end

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_op   <= op;
      item_char <= char_code;
    end
  end

  // Column with its bank lane and bank row
  always_ff @(posedge clk) begin
    if (rst || cmd.line_advance) begin
      column  <= '0;
      wr_lane <= '0;
      wr_row  <= '0;
    end else if (cmd.buf_write) begin
      column <= column + CW'(1);
      if (wr_lane == LANEW'(CELLS_PER_RESULT - 1)) begin
        wr_lane <= '0;
        wr_row  <= wr_row + BW'(1);
      end else begin
        wr_lane <= wr_lane + LANEW'(1);
      end
    end
  end

  // Row, line base and scroll origin
  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      line_base <= '0;
      origin    <= '0;
    end else if (cmd.line_advance) begin
      line_base <= wrap_add(line_base, AW'(LINE_WIDTH));
      if (row == RW'(SCREEN_LINES - 1)) begin
        origin <= wrap_add(origin, AW'(LINE_WIDTH));
      end else begin
        row <= row + RW'(1);
      end
    end
  end

  // Walk over a line in groups of cells
  always_ff @(posedge clk) begin
    if (rst) begin
      offset      <= '0;
      rd_row      <= '0;
      limit_blank <= 1'b0;
    end else if (cmd.flush_start || cmd.blank_start) begin
      offset      <= '0;
      rd_row      <= '0;
      limit_blank <= cmd.blank_start;
    end else if (cmd.chunk_advance) begin
      offset <= offset + CW'(CELLS_PER_RESULT);
      rd_row <= rd_row + BW'(1);
    end
  end

  // Line buffer: one bank per lane, read at the walk row
  for (genvar g = 0; g < CELLS_PER_RESULT; g++) begin : g_bank
    logic [15:0] mem [NROWS];

    always_ff @(posedge clk) begin
      if (cmd.buf_write && wr_lane == LANEW'(g)) begin
        mem[wr_row] <= {attribute, item_char};
      end
      rdata[g] <= mem[rd_row];
    end
  end

  // Group size and address
  assign limit       = limit_blank ? CW'(LINE_WIDTH) : column;
  assign remaining   = limit - offset;
  assign chunk_final = (remaining <= CW'(CELLS_PER_RESULT));
  assign n_cells     = chunk_final ? remaining : CW'(CELLS_PER_RESULT);
  assign addend      = (cmd.emit_sel == tclw_pkg::EMIT_CURSOR) ? column : offset;
  assign addr_sum    = wrap_add(line_base, AW'(addend));

  // Cell words, zero past the group size
  for (genvar j = 0; j < tclw_pkg::OUT_CELLS; j++) begin : g_cell
    if (j < CELLS_PER_RESULT) begin : g_used
      assign cell_src[j] = (CW'(j) < n_cells) ? (limit_blank ? blank : rdata[j]) : 16'd0;
    end else begin : g_unused
      assign cell_src[j] = 16'd0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last <= cmd.emit_last;
      case (cmd.emit_sel)
        tclw_pkg::EMIT_FLUSH, tclw_pkg::EMIT_BLANK: begin
          kind           <= tclw_pkg::KIND_VIDEO;
          cell_address   <= 14'(addr_sum);
          cell_q         <= cell_src;
          cell_count     <= 3'(n_cells);
          register_value <= '0;
        end
        tclw_pkg::EMIT_ORIGIN: begin
          kind           <= tclw_pkg::KIND_ORIGIN;
          cell_address   <= '0;
          cell_q         <= '{default: 16'd0};
          cell_count     <= '0;
          register_value <= 14'(origin);
        end
        default: begin
          kind           <= tclw_pkg::KIND_CURSOR;
          cell_address   <= '0;
          cell_q         <= '{default: 16'd0};
          cell_count     <= '0;
          register_value <= 14'(addr_sum);
        end
      endcase
    end
  end

  assign cell_zero  = cell_q[0];
  assign cell_one   = cell_q[1];
  assign cell_two   = cell_q[2];
  assign cell_three = cell_q[3];

  // Status to the controller
  assign stat.op_flush    = (item_op == tclw_pkg::OP_FLUSH);
  assign stat.newline     = (item_char == tclw_pkg::NEWLINE_CODE);
  assign stat.column_zero = (column == '0);
  assign stat.line_full   = (column == CW'(LINE_WIDTH));
  assign stat.last_row    = (row == RW'(SCREEN_LINES - 1));
  assign stat.chunk_final = chunk_final;
  assign stat.out_free    = !result_valid || !result_stall;

`ifndef SYNTHESIS
  // Never overwrite a result that is still stalled
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !result_valid || !result_stall)
    else $error("result register overwritten while stalled");

  // Column never runs past the line, nor row past the bottom row
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    column <= CW'(LINE_WIDTH) && row <= RW'(SCREEN_LINES - 1))
    else $error("column or row out of range");

  // Advancing past the bottom row moves the origin
  a_scroll_moves: assert property (@(posedge clk) disable iff (rst)
    cmd.line_advance && row == RW'(SCREEN_LINES - 1) |=> origin != $past(origin))
    else $error("scroll did not move the origin");
`endif

endmodule
